FILE: hdl/slr_pkg.sv
// Shared constants for the stereo linear resampler.
// Register indexes, field widths and saturation limits; no dependencies.
package slr_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int STEP_W     = 17;
    localparam int GAIN_W     = 9;
    localparam int PHASE_W    = 16;
    localparam int PEAK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN = 1'b1;

    localparam logic [STEP_W-1:0] STEP_MIN    = 17'd10922;
    localparam logic [STEP_W-1:0] STEP_MAX    = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_RESET  = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MAX    = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 9'd256;

endpackage

FILE: hdl/slr_mul.sv
// Shared signed multiplier with registered product.
// Used for both the interpolation and the gain products; no dependencies.
module slr_mul #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    logic signed [AW+BW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

FILE: hdl/stereo_linear_resampler_core.sv
// Stereo linear resampler top level: sequencer, state and stream ports.
// Each accepted pair (after priming) yields 1..7 output transactions, one per phase step.
// Each output takes four multiplier passes plus an output cycle; no new pair is taken mid-run.
// A priming pair (first after reset) yields nothing.
// Output stalls hold the sequencer at its output cycle. Depends on slr_pkg, slr_mul.
// rst_n (async, active low) clears control state, phase, peaks, config and previous samples, not payload registers.
module stereo_linear_resampler_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wen,
    input  logic [slr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // clear_peaks
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // left_out, right_out, peak_left, peak_right
    output logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0]  m_tdata,
    // last_of_run
    output logic                                   m_tlast
);

    import slr_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = SB + 1;
    localparam int BW  = PHASE_W + 1;
    localparam int PRW = AW + BW;
    localparam int MW  = (SB > PEAK_W) ? SB : PEAK_W;
    localparam int OW  = ((2*SB+32+7)/8)*8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ML1  = 3'd1;
    localparam logic [2:0] ST_ML2  = 3'd2;
    localparam logic [2:0] ST_MR1  = 3'd3;
    localparam logic [2:0] ST_MR2  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]           state_reg;
    logic [STEP_W-1:0]    phase_step_reg;
    logic [GAIN_W-1:0]    volume_gain_reg;
    logic signed [SB-1:0] prev_l_reg, prev_r_reg;
    logic signed [SB-1:0] new_l_reg, new_r_reg;
    logic                 primed_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PEAK_W-1:0]    peak_l_reg, peak_r_reg;
    logic signed [SB-1:0] res_l_reg;
    logic                 m_valid_reg;
    logic signed [SB-1:0] m_left_reg, m_right_reg;
    logic [PEAK_W-1:0]    m_peak_l_reg, m_peak_r_reg;
    logic                 m_last_reg;

    logic [STEP_W-1:0]    step_sat;
    logic [GAIN_W-1:0]    gain_sat;
    logic signed [AW-1:0] diff_l, diff_r;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PRW-1:0] prod;
    logic                 mul_en;
    logic signed [SB+1:0] v_sum;
    logic signed [SB-1:0] prev_sel;
    logic signed [SB-1:0] res_r;
    logic [SB-1:0]        abs_l, abs_r;
    logic [MW-1:0]        abs_l_ext, abs_r_ext;
    logic [PEAK_W-1:0]    peak_l_next, peak_r_next;
    logic [STEP_W:0]      acc;
    logic                 done;
    logic                 s_accept;
    logic                 fire;

    assign step_sat = (phase_step_reg < STEP_MIN) ? STEP_MIN :
                      (phase_step_reg > STEP_MAX) ? STEP_MAX : phase_step_reg;
    assign gain_sat = (volume_gain_reg > GAIN_MAX) ? GAIN_MAX : volume_gain_reg;

    assign diff_l = {new_l_reg[SB-1], new_l_reg} - {prev_l_reg[SB-1], prev_l_reg};
    assign diff_r = {new_r_reg[SB-1], new_r_reg} - {prev_r_reg[SB-1], prev_r_reg};

    // prev + floor((next - prev) * phase / 2^16); stays inside the sample range
    assign prev_sel = (state_reg == ST_ML2) ? prev_l_reg : prev_r_reg;
    assign v_sum    = {{2{prev_sel[SB-1]}}, prev_sel} + prod[PRW-1:PHASE_W];

    always_comb
    begin
        unique case (state_reg)
            ST_ML2, ST_MR2:
            begin
                mul_a = {v_sum[SB-1], v_sum[SB-1:0]};
                mul_b = {{(BW-GAIN_W){1'b0}}, gain_sat};
            end
            ST_MR1:
            begin
                mul_a = diff_r;
                mul_b = {1'b0, phase_reg};
            end
            default:
            begin
                mul_a = diff_l;
                mul_b = {1'b0, phase_reg};
            end
        endcase
    end

    assign mul_en = (state_reg != ST_FIN);

    slr_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign res_r = prod[SB+7:8];

    assign abs_l     = res_l_reg[SB-1] ? (~res_l_reg + 1'b1) : res_l_reg;
    assign abs_r     = res_r[SB-1] ? (~res_r + 1'b1) : res_r;
    assign abs_l_ext = MW'(abs_l);
    assign abs_r_ext = MW'(abs_r);

    assign peak_l_next = (abs_l_ext > MW'(peak_l_reg)) ? abs_l_ext[PEAK_W-1:0] : peak_l_reg;
    assign peak_r_next = (abs_r_ext > MW'(peak_r_reg)) ? abs_r_ext[PEAK_W-1:0] : peak_r_reg;

    assign acc  = {2'b00, phase_reg} + {1'b0, step_sat};
    assign done = |acc[STEP_W:PHASE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= STEP_RESET;
            volume_gain_reg <= GAIN_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_VOLUME_GAIN: volume_gain_reg <= cfg_data[GAIN_W-1:0];
                default:         phase_step_reg  <= phase_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            primed_reg  <= 1'b0;
            phase_reg   <= '0;
            peak_l_reg  <= '0;
            peak_r_reg  <= '0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tuser[0])
                        begin
                            peak_l_reg <= '0;
                            peak_r_reg <= '0;
                        end
                        if (!primed_reg)
                        begin
                            prev_l_reg <= s_tdata[SB-1:0];
                            prev_r_reg <= s_tdata[2*SB-1:SB];
                            primed_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_ML1;
                        end
                    end
                end
                ST_ML1: state_reg <= ST_ML2;
                ST_ML2: state_reg <= ST_MR1;
                ST_MR1: state_reg <= ST_MR2;
                ST_MR2: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (fire)
                    begin
                        peak_l_reg  <= peak_l_next;
                        peak_r_reg  <= peak_r_next;
                        phase_reg   <= acc[PHASE_W-1:0];
                        if (done)
                        begin
                            prev_l_reg <= new_l_reg;
                            prev_r_reg <= new_r_reg;
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_ML1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept && primed_reg)
        begin
            new_l_reg <= s_tdata[SB-1:0];
            new_r_reg <= s_tdata[2*SB-1:SB];
        end
        if (state_reg == ST_MR1)
        begin
            res_l_reg <= prod[SB+7:8];
        end
        if (fire)
        begin
            m_left_reg   <= res_l_reg;
            m_right_reg  <= res_r;
            m_peak_l_reg <= peak_l_next;
            m_peak_r_reg <= peak_r_next;
            m_last_reg   <= done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OW'({m_peak_r_reg, m_peak_l_reg, m_right_reg, m_left_reg});

endmodule

FILE: hdl/slr_checker.sv
// Port-level checks for stereo_linear_resampler_core, attached by bind.
// Depends on slr_pkg for port widths.
module slr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   cfg_wen,
    input logic [slr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input logic [slr_pkg::CFG_DATA_W-1:0]         cfg_data,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input logic [0:0]                             s_tuser,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0]  m_tdata,
    input logic                                   m_tlast
);

    import slr_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic signed [SB-1:0] left_s, right_s;
    logic [SB:0]          abs_l, abs_r;
    logic [31:0]          abs_l32, abs_r32, peak_l32, peak_r32;

    assign left_s   = m_tdata[SB-1:0];
    assign right_s  = m_tdata[2*SB-1:SB];
    assign abs_l    = left_s[SB-1] ? ({1'b0, ~left_s} + 1'b1) : {1'b0, left_s};
    assign abs_r    = right_s[SB-1] ? ({1'b0, ~right_s} + 1'b1) : {1'b0, right_s};
    assign abs_l32  = 32'(abs_l);
    assign abs_r32  = 32'(abs_r);
    assign peak_l32 = 32'(m_tdata[2*SB+PEAK_W-1:2*SB]);
    assign peak_r32 = 32'(m_tdata[2*SB+2*PEAK_W-1:2*SB+PEAK_W]);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_peak_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (SB <= PEAK_W) |-> peak_l32 >= abs_l32)
        else $error("left peak below output magnitude");

    a_peak_right: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (SB <= PEAK_W) |-> peak_r32 >= abs_r32)
        else $error("right peak below output magnitude");

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a run");

endmodule

bind stereo_linear_resampler_core slr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_slr_checker (.*);
